/* rtl/core/priority_ready_queue_scheduler_unit_macros.svh */
// Assertion macros for the priority ready-queue scheduler.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTH
`define PRQS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PRQS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PRQS_ASSERT(label, clk, rst_n, prop, msg)
`define PRQS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/core/prqs_pkg.sv */
// Types and constants shared by the priority ready-queue scheduler.
package prqs_pkg;
  localparam int unsigned Threads = 64;
  localparam int unsigned Levels = 32;
  localparam int unsigned TidW = $clog2(Threads);
  localparam int unsigned LinkW = $clog2(Threads + 1);
  localparam int unsigned LvlW = $clog2(Levels);
  localparam int unsigned CntW = $clog2(Threads + 1);
  localparam logic [LinkW-1:0] Nil = LinkW'(Threads);
  localparam logic [31:0] SliceReset = 32'd10000000;

  typedef enum logic [2:0] {
    KindEnq = 3'd0, KindDeq = 3'd1, KindRem = 3'd2,
    KindTick = 3'd3, KindChg = 3'd4, KindQuery = 3'd5,
    KindNop6 = 3'd6, KindNop7 = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StEmpty = 2'd1, StQueued = 2'd2, StRsvd = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SEntry, SPrevRd, SPrevWr, SNextRd, SNextWr,
    SAppend, STailRd, STailWr, SOut
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  thread_id;
    logic signed [7:0] priority_req;
    logic [31:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [5:0] picked_thread;
    logic       picked_valid;
    logic       preempt_hint;
    logic [6:0] ready_count;
    logic [1:0] status;
  } out_item_t;

  // One thread entry in the thread memory.
  typedef struct packed {
    logic [LinkW-1:0] next;
    logic [LinkW-1:0] prev;
    logic [LvlW-1:0]  level;
    logic             queued;
    logic [31:0]      slice;
  } thr_t;

  localparam int unsigned ThrW = $bits(thr_t);

  function automatic logic [LvlW-1:0] clamp_level(logic signed [7:0] p);
    logic [LvlW-1:0] r;
    if (p < 0) r = '0;
    else if (32'(p) > Levels - 1) r = LvlW'(Levels - 1);
    else r = LvlW'(p);
    return r;
  endfunction
endpackage

/* rtl/core/prqs_ram.sv */
// Generic single-port synchronous RAM with registered read.
module prqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* rtl/core/prqs_ctrl.sv */
// Sequencer that runs each scheduler operation against the thread memory.
module prqs_ctrl
  import prqs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic [31:0] slice_len_i,
  output logic      busy_o
);
  state_e state_q, state_d;
  in_item_t op_q;
  out_item_t res_q, res_d;
  logic [TidW-1:0] tid_q, tid_d;   // thread worked on
  thr_t ent_q, ent_d;              // that thread's entry as first read
  logic [LinkW-1:0] nb_q, nb_d;    // old tail of the append level
  logic [LinkW-1:0] head_q [Levels];
  logic [LinkW-1:0] tail_q [Levels];
  logic [Levels-1:0] occ_q, occ_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  // Valid bits stand in for the reset of the thread memory.
  logic [Threads-1:0] vld_q;
  logic rvld_q;

  logic we;
  logic [TidW-1:0] addr;
  thr_t wdata, rdata, rd;
  logic [ThrW-1:0] rraw;

  // Head and tail updates of the current step.
  logic hw, tw;
  logic [LvlW-1:0] hl, tl;
  logic [LinkW-1:0] hv, tv;

  logic hi_any;
  logic [LvlW-1:0] hi_lvl;
  logic [LvlW-1:0] new_lvl;
  logic [LinkW-1:0] app_tail;
  logic unl_ok;
  state_e unl_next, unl_done;
  kind_e kind;

  prqs_ram #(.Width(ThrW), .Depth(Threads)) u_thr (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rraw)
  );

  assign rdata = thr_t'(rraw);
  assign kind = kind_e'(op_q.kind);
  assign new_lvl = clamp_level(op_q.priority_req);
  assign app_tail = tail_q[new_lvl];

  always_comb begin
    hi_any = |occ_q;
    hi_lvl = '0;
    for (int i = 0; i < Levels; i++) if (occ_q[i]) hi_lvl = LvlW'(i);
  end

  // An entry never written reads as an idle thread at level 0 with an empty slice.
  always_comb begin
    rd = rdata;
    if (!rvld_q) begin
      rd = '0;
      rd.next = Nil;
      rd.prev = Nil;
    end
  end

  // Unlink decision for the entry read in SEntry, and the path through the neighbors.
  always_comb begin
    case (kind)
      KindDeq: unl_ok = hi_any;
      KindRem, KindChg: unl_ok = rd.queued;
      default: unl_ok = 1'b0;
    endcase
    unl_done = (kind == KindChg) ? SAppend : SOut;
    if (rd.prev != Nil) unl_next = SPrevRd;
    else if (rd.next != Nil) unl_next = SNextRd;
    else unl_next = unl_done;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_valid_i) state_d = SEntry;
      SEntry: begin
        if (unl_ok) state_d = unl_next;
        else if (kind == KindEnq && !rd.queued) state_d = SAppend;
        else state_d = SOut;
      end
      SPrevRd: state_d = SPrevWr;
      SPrevWr: state_d = (ent_q.next != Nil) ? SNextRd : unl_done;
      SNextRd: state_d = SNextWr;
      SNextWr: state_d = unl_done;
      SAppend: state_d = (app_tail != Nil) ? STailRd : SOut;
      STailRd: state_d = STailWr;
      STailWr: state_d = SOut;
      SOut:    if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    tid_d = tid_q; ent_d = ent_q; nb_d = nb_q; res_d = res_q;
    occ_d = occ_q; cnt_d = cnt_q;
    we = 1'b0; addr = tid_q; wdata = rd;
    hw = 1'b0; hl = '0; hv = Nil; tw = 1'b0; tl = '0; tv = Nil;
    case (state_q)
      SIdle: begin
        tid_d = in_data_i.thread_id;
        if (kind_e'(in_data_i.kind) == KindDeq) tid_d = head_q[hi_lvl][TidW-1:0];
        addr = tid_d;
        res_d = '0;
      end
      SEntry: begin
        ent_d = rd;
        case (kind)
          KindEnq: begin
            if (rd.queued) res_d.status = StQueued;
            else cnt_d = cnt_q + 1'b1;
          end
          KindDeq: begin
            if (!hi_any) begin
              res_d.status = StEmpty;
            end else begin
              res_d.picked_thread = tid_q;
              res_d.picked_valid = 1'b1;
              cnt_d = cnt_q - 1'b1;
            end
          end
          KindRem: begin
            if (!rd.queued) res_d.status = StEmpty;
            else cnt_d = cnt_q - 1'b1;
          end
          KindTick: begin
            we = 1'b1;
            wdata.slice = (rd.slice > op_q.elapsed) ? rd.slice - op_q.elapsed : 32'd0;
          end
          KindChg: begin
            if (!rd.queued) begin
              we = 1'b1;
              wdata.level = new_lvl;
            end
          end
          KindQuery: begin
            res_d.preempt_hint = (hi_any && hi_lvl > rd.level) ||
                                 (rd.slice == 32'd0 && occ_q[rd.level]);
          end
          default: ;
        endcase
        if (unl_ok) begin
          // Clear the thread's links; the neighbors are patched in the next states.
          we = 1'b1; wdata.queued = 1'b0; wdata.next = Nil; wdata.prev = Nil;
          if (rd.prev == Nil) begin hw = 1'b1; hl = rd.level; hv = rd.next; end
          if (rd.next == Nil) begin tw = 1'b1; tl = rd.level; tv = rd.prev; end
          if (rd.prev == Nil && rd.next == Nil) occ_d[rd.level] = 1'b0;
        end
      end
      SPrevRd: addr = ent_q.prev[TidW-1:0];
      SPrevWr: begin
        addr = ent_q.prev[TidW-1:0];
        we = 1'b1;
        wdata.next = ent_q.next;
      end
      SNextRd: addr = ent_q.next[TidW-1:0];
      SNextWr: begin
        addr = ent_q.next[TidW-1:0];
        we = 1'b1;
        wdata.prev = ent_q.prev;
      end
      SAppend: begin
        we = 1'b1;
        wdata = ent_q;
        wdata.next = Nil; wdata.prev = app_tail;
        wdata.level = new_lvl; wdata.queued = 1'b1;
        if (kind == KindEnq) wdata.slice = slice_len_i;
        tw = 1'b1; tl = new_lvl; tv = LinkW'(tid_q);
        if (app_tail == Nil) begin
          hw = 1'b1; hl = new_lvl; hv = LinkW'(tid_q); occ_d[new_lvl] = 1'b1;
        end
        nb_d = app_tail;
      end
      STailRd: addr = nb_q[TidW-1:0];
      STailWr: begin
        addr = nb_q[TidW-1:0];
        we = 1'b1;
        wdata.next = LinkW'(tid_q);
      end
      SOut: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      occ_q <= '0; cnt_q <= '0; vld_q <= '0;
      for (int i = 0; i < Levels; i++) begin head_q[i] <= Nil; tail_q[i] <= Nil; end
    end else begin
      state_q <= state_d;
      occ_q <= occ_d; cnt_q <= cnt_d;
      if (we) vld_q[addr] <= 1'b1;
      if (hw) head_q[hl] <= hv;
      if (tw) tail_q[tl] <= tv;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; tid_q <= tid_d; ent_q <= ent_d; nb_q <= nb_d;
    rvld_q <= vld_q[addr];
    if (state_q == SIdle && in_valid_i) op_q <= in_data_i;
  end

  always_comb begin
    out_data_o = res_q;
    out_data_o.ready_count = cnt_q;
  end

  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign busy_o = (state_q != SIdle);
endmodule

/* rtl/core/priority_ready_queue_scheduler_unit.sv */
// Ready-queue scheduler with 32 priority levels, each a first-in first-out list of
// thread ids, the highest non-empty level served first. One transaction is in flight
// at a time. Each thread's links, level, queued flag and slice sit in a single-port
// memory with a registered read; head and tail per level, the level bitmap and the
// ready count are flip-flops. A tick, a query, a refusal or an empty dequeue goes
// straight to the result; an enqueue appends the entry and patches the old tail when
// the level is not empty, a dequeue or remove patches each neighbor (read, then write),
// and moving a queued thread unlinks it and then appends it. A new transaction is taken
// the cycle after the result leaves. Write timeslice_length only while the block is idle.
`include "priority_ready_queue_scheduler_unit_macros.svh"
module priority_ready_queue_scheduler_unit
  import prqs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);
  logic [31:0] slice_len_q;
  logic busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_len_q <= SliceReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      slice_len_q <= pwdata;
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? slice_len_q : 32'd0;

  prqs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .slice_len_i(slice_len_q), .busy_o(busy)
  );

  `PRQS_ASSERT(a_ready_idle, clk_i, rst_ni, !(in_ready_o && out_valid_o), "ready while result pending")
  `PRQS_ASSERT_NEXT(a_busy_after_acc, clk_i, rst_ni, in_valid_i && in_ready_o, busy, "not busy after accept")
  `PRQS_ASSERT(a_count_max, clk_i, rst_ni, !out_valid_o || out_data_o.ready_count <= 7'd64, "count overflow")
endmodule
